@@ src/lbh_pkg.sv @@
// shared types and constants for the latitude band histogram
// no dependencies; imported by every module of the block
`default_nettype none

package lbh_pkg;

	localparam int LBH_LAT_W  = 14;  // latitude, band_low, counts
	localparam int LBH_HIGH_W = 15;  // band_high
	localparam int LBH_QW     = 6;   // band index: at most 9000 / 200 = 45
	localparam int LBH_ADDR_W = 3;
	localparam int LBH_DATA_W = 32;

	localparam logic [LBH_LAT_W-1:0] LAT_MAX   = 14'd9000;
	localparam logic [LBH_LAT_W-1:0] WIDTH_MIN = 14'd200;

	// operation codes
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// register index (byte address / 4)
	localparam logic REG_BAND_WIDTH = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_GO,
		ST_ADD_DIV,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_LO_GO,
		ST_LO_DIV,
		ST_HI_GO,
		ST_HI_DIV,
		ST_PREV_RD,
		ST_PREV_ACC,
		ST_J_RD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DIV_SAMPLE,
		DIV_LOWEST,
		DIV_HIGHEST
	} div_sel_t;

	typedef enum logic [1:0] {
		RD_SLOT,
		RD_CUR,
		RD_PREV
	} rd_sel_t;

	typedef struct packed {
		logic     sample_load;
		logic     div_start;
		div_sel_t div_sel;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     add_write;
		logic     store_first;
		logic     store_last;
		logic     acc_load;
		logic     out_load;
		logic     clear_store;
	} cmd_t;

	typedef struct packed {
		logic any;
		logic div_done;
		logic merge;
		logic at_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ src/lbh_div.sv @@
// restoring divider, one quotient bit per cycle, quotient known to fit LBH_QW bits
// depends on lbh_pkg
`default_nettype none

module lbh_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [lbh_pkg::LBH_LAT_W-1:0] dividend,
	input  wire logic [lbh_pkg::LBH_LAT_W-1:0] divisor,
	output logic      [lbh_pkg::LBH_QW-1:0]    quo,
	output logic      [lbh_pkg::LBH_LAT_W-1:0] rem,
	output logic                               done
);
	import lbh_pkg::*;

	localparam int DW = LBH_LAT_W + LBH_QW - 1;
	localparam int CW = $clog2(LBH_QW);

	logic [DW-1:0]        den_q;
	logic [LBH_LAT_W-1:0] rem_q;
	logic [LBH_QW-1:0]    quo_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 ge;

	assign ge = {{(LBH_QW-1){1'b0}}, rem_q} >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(LBH_QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= {divisor, {(LBH_QW-1){1'b0}}};
			rem_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			// subtrahend fits the remainder width whenever ge holds
			if (ge) begin
				rem_q <= rem_q - den_q[LBH_LAT_W-1:0];
			end
			quo_q <= {quo_q[LBH_QW-2:0], ge};
			den_q <= den_q >> 1;
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ src/lbh_dpath.sv @@
// datapath: band store, divider, extremes, readout walk and output register
// depends on lbh_pkg and lbh_div
`default_nettype none

module lbh_dpath #(
	parameter int BAND_SLOTS  = 64,
	parameter int MAX_SAMPLES = 16383
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lbh_pkg::cmd_t                  cmd,
	output lbh_pkg::sts_t                       sts,
	input  wire logic                           cfg_clear,
	input  wire logic [lbh_pkg::LBH_LAT_W-1:0]  band_width,
	input  wire logic [lbh_pkg::LBH_LAT_W-1:0]  latitude,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [lbh_pkg::LBH_LAT_W-1:0]  band_low,
	output logic      [lbh_pkg::LBH_HIGH_W-1:0] band_high,
	output logic      [lbh_pkg::LBH_LAT_W-1:0]  band_count,
	output logic                                last
);
	import lbh_pkg::*;

	localparam int AW = $clog2(BAND_SLOTS);
	localparam int CAP_I = (MAX_SAMPLES > 16383) ? 16383 : MAX_SAMPLES;
	localparam logic [LBH_LAT_W-1:0] COUNT_CAP = LBH_LAT_W'(CAP_I);

	logic [LBH_LAT_W-1:0]  eff_w;
	logic [LBH_LAT_W-1:0]  x_q;
	logic [LBH_LAT_W-1:0]  lowest_q;
	logic [LBH_LAT_W-1:0]  highest_q;
	logic                  any_q;
	logic [LBH_LAT_W-1:0]  dividend;
	logic [LBH_QW-1:0]     quo;
	logic [LBH_LAT_W-1:0]  rem;
	logic                  div_done;

	logic [LBH_LAT_W-1:0]  mem [BAND_SLOTS];
	logic [BAND_SLOTS-1:0] vld_q;
	logic [LBH_QW-1:0]     rd_slot;
	logic [AW-1:0]         rd_addr;
	logic                  rd_in_range;
	logic [LBH_LAT_W-1:0]  rd_data_q;
	logic                  rd_hit_q;
	logic [LBH_LAT_W-1:0]  rd_val;
	logic                  wr_in_range;
	logic [LBH_LAT_W-1:0]  inc_val;

	logic [LBH_QW-1:0]     j_q;
	logic [LBH_QW-1:0]     last_q;
	logic                  merge_q;
	logic [LBH_HIGH_W-1:0] low_q;
	logic [LBH_LAT_W-1:0]  acc_q;
	logic [LBH_HIGH_W-1:0] sum;
	logic [LBH_LAT_W-1:0]  sat_sum;
	logic [LBH_HIGH_W-1:0] next_low;
	logic                  clear_all;

	logic                  out_valid_q;
	logic [LBH_LAT_W-1:0]  band_low_q;
	logic [LBH_HIGH_W-1:0] band_high_q;
	logic [LBH_LAT_W-1:0]  band_count_q;
	logic                  last_q_out;

	// width clamped into the legal band range, never zero
	always_comb begin
		eff_w = band_width;
		if (band_width < WIDTH_MIN) begin
			eff_w = WIDTH_MIN;
		end else if (band_width > LAT_MAX) begin
			eff_w = LAT_MAX;
		end
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_SAMPLE:  dividend = (x_q == '0) ? '0 : x_q - 1'b1;
			DIV_LOWEST:  dividend = lowest_q;
			DIV_HIGHEST: dividend = (highest_q == '0) ? '0 : highest_q - 1'b1;
			default:     dividend = '0;
		endcase
	end

	lbh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (eff_w),
		.quo      (quo),
		.rem      (rem),
		.done     (div_done)
	);

	always_comb begin
		case (cmd.rd_sel)
			RD_SLOT: rd_slot = quo;
			RD_CUR:  rd_slot = j_q;
			RD_PREV: rd_slot = j_q - 1'b1;
			default: rd_slot = j_q;
		endcase
	end

	assign rd_addr     = AW'(rd_slot);
	assign rd_in_range = 32'(rd_slot) < BAND_SLOTS;
	assign wr_in_range = 32'(quo) < BAND_SLOTS;
	assign rd_val      = rd_hit_q ? rd_data_q : '0;
	assign inc_val     = (rd_val < COUNT_CAP) ? rd_val + 1'b1 : rd_val;
	assign clear_all   = cmd.clear_store || cfg_clear;

	// band store: entries not marked valid read as zero
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.add_write && wr_in_range) begin
			mem[AW'(quo)] <= inc_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_hit_q <= rd_in_range && vld_q[rd_addr];
			end
			if (clear_all) begin
				vld_q <= '0;
			end else if (cmd.add_write && wr_in_range) begin
				vld_q[AW'(quo)] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sample_load) begin
			x_q <= (latitude > LAT_MAX) ? LAT_MAX : latitude;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q  <= LAT_MAX;
			highest_q <= '0;
			any_q     <= 1'b0;
		end else if (clear_all) begin
			lowest_q  <= LAT_MAX;
			highest_q <= '0;
			any_q     <= 1'b0;
		end else if (cmd.add_write) begin
			if (x_q < lowest_q) begin
				lowest_q <= x_q;
			end
			if (x_q > highest_q) begin
				highest_q <= x_q;
			end
			any_q <= 1'b1;
		end
	end

	// readout walk
	assign next_low = low_q + {1'b0, eff_w};
	assign sum      = {1'b0, acc_q} + {1'b0, rd_val};
	assign sat_sum  = (sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : sum[LBH_LAT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.store_first) begin
			j_q     <= quo;
			low_q   <= {1'b0, lowest_q} - {1'b0, rem};
			// lowest on a band edge: the slot below belongs to the first band
			merge_q <= (rem == '0) && (lowest_q != '0);
		end else if (cmd.out_load) begin
			j_q   <= j_q + 1'b1;
			low_q <= next_low;
		end
		if (cmd.store_last) begin
			last_q <= (quo < j_q) ? j_q : quo;
		end
		if (cmd.store_last || cmd.out_load) begin
			acc_q <= '0;
		end else if (cmd.acc_load) begin
			acc_q <= rd_val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			band_low_q   <= low_q[LBH_LAT_W-1:0];
			band_high_q  <= next_low;
			band_count_q <= sat_sum;
			last_q_out   <= (j_q == last_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign band_low   = band_low_q;
	assign band_high  = band_high_q;
	assign band_count = band_count_q;
	assign last       = last_q_out;

	assign sts.any      = any_q;
	assign sts.div_done = div_done;
	assign sts.merge    = merge_q;
	assign sts.at_last  = (j_q == last_q);
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

@@ src/lbh_ctrl.sv @@
// controller: sequences sample adds and the band readout
// depends on lbh_pkg
`default_nettype none

module lbh_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          operation,
	output logic               in_stall,
	output lbh_pkg::cmd_t      cmd,
	input  wire lbh_pkg::sts_t sts
);
	import lbh_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (operation == OP_ADD) begin
						state_d = ST_ADD_GO;
					end else if (sts.any) begin
						state_d = ST_LO_GO;
					end
				end
			end
			ST_ADD_GO:   state_d = ST_ADD_DIV;
			ST_ADD_DIV:  if (sts.div_done) state_d = ST_ADD_RD;
			ST_ADD_RD:   state_d = ST_ADD_WR;
			ST_ADD_WR:   state_d = ST_IDLE;
			ST_LO_GO:    state_d = ST_LO_DIV;
			ST_LO_DIV:   if (sts.div_done) state_d = ST_HI_GO;
			ST_HI_GO:    state_d = ST_HI_DIV;
			ST_HI_DIV: begin
				if (sts.div_done) begin
					state_d = sts.merge ? ST_PREV_RD : ST_J_RD;
				end
			end
			ST_PREV_RD:  state_d = ST_PREV_ACC;
			ST_PREV_ACC: state_d = ST_J_RD;
			ST_J_RD:     state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.at_last ? ST_IDLE : ST_J_RD;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.div_sel = DIV_SAMPLE;
		cmd.rd_sel  = RD_CUR;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				cmd.sample_load = in_valid && (operation == OP_ADD);
			end
			ST_ADD_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SAMPLE;
			end
			ST_ADD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SLOT;
			end
			ST_ADD_WR:   cmd.add_write = 1'b1;
			ST_LO_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_LOWEST;
			end
			ST_LO_DIV: begin
				cmd.div_sel     = DIV_LOWEST;
				cmd.store_first = sts.div_done;
			end
			ST_HI_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_HIGHEST;
			end
			ST_HI_DIV: begin
				cmd.div_sel    = DIV_HIGHEST;
				cmd.store_last = sts.div_done;
			end
			ST_PREV_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PREV;
			end
			ST_PREV_ACC: cmd.acc_load = 1'b1;
			ST_J_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_CUR;
			end
			ST_EMIT: begin
				cmd.out_load    = sts.out_free;
				cmd.clear_store = sts.out_free && sts.at_last;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/latitude_band_histogram.sv @@
// latitude band histogram: a sample word passes a start step, band index division,
// a store read, a store write and the idle state before the next input is taken. a
// finish word runs two divisions, a read of the slot below when the lowest sample
// sits on a band edge, then a store read and an output load per band, the load waiting
// while the output stalls; with no samples it gives no output. reset clears the band
// store (valid flags), extremes and width (200); no clearing pass, inputs taken at once
`default_nettype none

module latitude_band_histogram #(
	parameter int BAND_SLOTS  = 64,
	parameter int MAX_SAMPLES = 16383
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [lbh_pkg::LBH_ADDR_W-1:0] paddr,
	input  wire logic [lbh_pkg::LBH_DATA_W-1:0] pwdata,
	output logic      [lbh_pkg::LBH_DATA_W-1:0] prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           operation,
	input  wire logic [lbh_pkg::LBH_LAT_W-1:0]  latitude,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [lbh_pkg::LBH_LAT_W-1:0]  band_low,
	output logic      [lbh_pkg::LBH_HIGH_W-1:0] band_high,
	output logic      [lbh_pkg::LBH_LAT_W-1:0]  band_count,
	output logic                                last
);
	import lbh_pkg::*;

	logic [LBH_LAT_W-1:0] band_width_q;
	logic                 reg_idx;
	logic                 cfg_wr;
	logic                 cfg_clear;
	cmd_t                 cmd;
	sts_t                 sts;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[2];
	assign cfg_wr    = psel && penable && pwrite;
	assign cfg_clear = cfg_wr && (reg_idx == REG_BAND_WIDTH);
	assign prdata    = (reg_idx == REG_BAND_WIDTH) ?
		{{(LBH_DATA_W-LBH_LAT_W){1'b0}}, band_width_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_width_q <= WIDTH_MIN;
		end else if (cfg_clear) begin
			band_width_q <= pwdata[LBH_LAT_W-1:0];
		end
	end

	lbh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	lbh_dpath #(
		.BAND_SLOTS  (BAND_SLOTS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_clear  (cfg_clear),
		.band_width (band_width_q),
		.latitude   (latitude),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.band_low   (band_low),
		.band_high  (band_high),
		.band_count (band_count),
		.last       (last)
	);

	// a pending word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("output word overwritten while stalled");

	// each divider start is followed by its done pulse
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> ##(LBH_QW + 1) sts.div_done)
		else $error("divider done pulse out of place");

	// the final band of a readout empties the store
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && sts.at_last) |=> !sts.any)
		else $error("store not cleared after readout");

	// no input is taken while a readout or add is in flight
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_start || cmd.rd_en || cmd.out_load) |-> in_stall)
		else $error("input accepted while busy");

endmodule

`default_nettype wire
